// File: design/shqrp_pkg.sv
// Shared types and constants for the quaternion report parser.
package shqrp_pkg;

  // Packet framing
  localparam logic [14:0] HEADER_LEN        = 15'd4;
  localparam logic [14:0] MAX_PAYLOAD_RESET = 15'd128;
  localparam logic [7:0]  REPORT_ID         = 8'h05;
  localparam int          REPORT_SPAN       = 13;
  localparam int          REPORT_IDX_W      = $clog2(REPORT_SPAN);

  // Result codes
  localparam logic [1:0] RC_REPORT    = 2'd0;
  localparam logic [1:0] RC_NO_REPORT = 2'd1;
  localparam logic [1:0] RC_TOO_SHORT = 2'd2;
  localparam logic [1:0] RC_TOO_LARGE = 2'd3;

  // Header byte slots
  localparam logic [1:0] HB_LEN_LO = 2'd0;
  localparam logic [1:0] HB_LEN_HI = 2'd1;
  localparam logic [1:0] HB_CHAN   = 2'd2;
  localparam logic [1:0] HB_SEQ    = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_packet;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         result_code;
    logic signed [15:0] quat_real;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic [15:0]        heading_accuracy;
    logic [1:0]         status_bits;
    logic [14:0]        payload_length;
  } out_beat_t;

endpackage

// File: design/sensor_hub_quaternion_report_parser.sv
// Top level of the sensor-hub quaternion report parser.
// Takes one packet byte per beat and sustains one byte per cycle while the
// result side has room: a byte is registered, parsed by a single pass of
// compare and capture logic against the packet state, and any result is loaded
// into the result register when the parser takes the byte that closes the
// packet (4th header byte for error, empty or too-large packets, last payload
// byte otherwise). The result register stalls the byte path only while a
// waiting result is held. Quaternion parts are raw Q14 and accuracy raw Q12;
// the payload limit is written through cfg_wr_en/cfg_wr_data, only while the
// block is idle; the user must ensure this, as the block does not enforce it.
module sensor_hub_quaternion_report_parser import shqrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_beat_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_beat_t   result
);

  logic      beat_valid;
  in_beat_t  beat;
  logic      out_ready;
  logic      fire;
  logic      emit;
  out_beat_t res;

  // Parser moves when a byte is held and the result side has room
  assign fire = beat_valid && out_ready;

  shqrp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .beat_valid (beat_valid),
    .beat       (beat),
    .advance    (fire)
  );

  shqrp_parser u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .beat        (beat),
    .emit        (emit),
    .res         (res)
  );

  shqrp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && emit),
    .load_beat    (res),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: design/shqrp_in_stage.sv
// Input register: holds one byte beat until the parser takes it.
module shqrp_in_stage import shqrp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_beat_t item,
  output logic     beat_valid,
  output in_beat_t beat,
  input  logic     advance
);

  // Stall only while a held beat is not moving on
  assign item_stall = beat_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      beat_valid <= 1'b1;
    end else if (advance) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      beat <= item;
    end
  end

endmodule

// File: design/shqrp_parser.sv
// Packet parse state, report capture and result formation for one byte a cycle while the parser fires.
module shqrp_parser import shqrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        fire,
  input  in_beat_t    beat,
  output logic        emit,
  output out_beat_t   res
);

  phase_t      phase, phase_next;
  logic [1:0]  hdr_cnt, hdr_cnt_next;
  logic [7:0]  len_low, len_low_next;
  logic [14:0] total, total_next;
  logic [14:0] pos, pos_next;
  logic        found, found_next;
  logic [3:0]  cap_cnt, cap_cnt_next;
  logic [7:0]  rep [REPORT_SPAN];
  logic [7:0]  rep_next [REPORT_SPAN];
  logic [14:0] max_len;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  // Next state and result for the current beat
  always_comb begin
    phase_t      ph;
    logic [1:0]  cnt;
    logic [14:0] tsub;
    logic [15:0] pos_inc;
    logic [15:0] pos_span;

    ph = phase;
    cnt = hdr_cnt;
    if (beat.first_of_packet) begin
      ph = PH_HEADER;
      cnt = HB_LEN_LO;
    end

    phase_next   = ph;
    hdr_cnt_next = cnt;
    len_low_next = len_low;
    total_next   = total;
    pos_next     = pos;
    found_next   = found;
    cap_cnt_next = cap_cnt;
    rep_next     = rep;
    emit         = 1'b0;
    res          = '0;
    tsub         = total - HEADER_LEN;
    pos_inc      = {1'b0, pos} + 16'd1;
    pos_span     = {1'b0, pos} + 16'(REPORT_SPAN);

    if (ph == PH_PAYLOAD) begin
      // Capture the bytes after the report id, or look for the id
      if (found) begin
        if (cap_cnt < 4'(REPORT_SPAN)) begin
          rep_next[cap_cnt[REPORT_IDX_W-1:0]] = beat.data_byte;
          cap_cnt_next = cap_cnt + 4'd1;
        end
      end else if (beat.data_byte == REPORT_ID && pos_span < {1'b0, total}) begin
        found_next   = 1'b1;
        cap_cnt_next = 4'd0;
      end
      pos_next = pos_inc[14:0];
      // Last payload byte closes the packet
      if (pos_inc >= {1'b0, total}) begin
        phase_next   = PH_HEADER;
        hdr_cnt_next = HB_LEN_LO;
        emit         = 1'b1;
        res.payload_length = total;
        if (found_next && cap_cnt_next >= 4'(REPORT_SPAN)) begin
          res.result_code      = RC_REPORT;
          res.quat_real        = $signed({rep_next[4],  rep_next[3]});
          res.quat_i           = $signed({rep_next[6],  rep_next[5]});
          res.quat_j           = $signed({rep_next[8],  rep_next[7]});
          res.quat_k           = $signed({rep_next[10], rep_next[9]});
          res.heading_accuracy = {rep_next[12], rep_next[11]};
          res.status_bits      = rep_next[1][1:0];
        end else begin
          res.result_code = RC_NO_REPORT;
        end
      end
    end else begin
      case (cnt)
        HB_LEN_LO: begin
          len_low_next = beat.data_byte;
          hdr_cnt_next = HB_LEN_HI;
        end
        HB_LEN_HI: begin
          // Top bit of the high byte is the continuation flag
          total_next   = {beat.data_byte[6:0], len_low};
          hdr_cnt_next = HB_CHAN;
        end
        HB_CHAN: begin
          hdr_cnt_next = HB_SEQ;
        end
        default: begin
          hdr_cnt_next = HB_LEN_LO;
          phase_next   = PH_HEADER;
          if (total < HEADER_LEN) begin
            total_next      = '0;
            emit            = 1'b1;
            res.result_code = RC_TOO_SHORT;
          end else begin
            total_next = tsub;
            if (tsub > max_len) begin
              emit               = 1'b1;
              res.result_code    = RC_TOO_LARGE;
              res.payload_length = tsub;
            end else if (tsub == '0) begin
              emit            = 1'b1;
              res.result_code = RC_NO_REPORT;
            end else begin
              phase_next   = PH_PAYLOAD;
              pos_next     = '0;
              found_next   = 1'b0;
              cap_cnt_next = 4'd0;
            end
          end
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      hdr_cnt <= HB_LEN_LO;
      len_low <= '0;
      total   <= '0;
      pos     <= '0;
      found   <= 1'b0;
      cap_cnt <= '0;
    end else if (fire) begin
      phase   <= phase_next;
      hdr_cnt <= hdr_cnt_next;
      len_low <= len_low_next;
      total   <= total_next;
      pos     <= pos_next;
      found   <= found_next;
      cap_cnt <= cap_cnt_next;
    end
  end

  // Captured report bytes
  always_ff @(posedge clk) begin
    if (fire) begin
      rep <= rep_next;
    end
  end

endmodule

// File: design/shqrp_out_stage.sv
// Result register: holds one result beat until downstream takes it.
module shqrp_out_stage import shqrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_beat_t load_beat,
  output logic      ready,
  output logic      result_valid,
  input  logic      result_stall,
  output out_beat_t result
);

  // Room when empty or when the held beat leaves this cycle
  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      result <= load_beat;
    end
  end

endmodule
